[src/fcar_pkg.sv]
// Shared constants and character tables for the framed command and ack core.
package fcar_pkg;

  // Item kinds on the input channel
  localparam logic OPC_BYTE = 1'b0;
  localparam logic OPC_TICK = 1'b1;

  // Framing and packet characters
  localparam logic [7:0] START_MARK = 8'h21;
  localparam logic [7:0] END_MARK   = 8'h23;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // Command and packet head lengths, marks included
  localparam int RST_LEN  = 5;
  localparam int OK_LEN   = 4;
  localparam int HEAD_LEN = 5;

  // Tick counter and timeout register
  localparam int          TICK_W        = 16;
  localparam logic [15:0] TICK_MAX      = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // Reset command text "!RST#"
  function automatic logic [7:0] rst_text(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h21;
      3'd1:    c = 8'h52;
      3'd2:    c = 8'h53;
      3'd3:    c = 8'h54;
      3'd4:    c = 8'h23;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Acknowledge command text "!OK#"
  function automatic logic [7:0] ok_text(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h21;
      3'd1:    c = 8'h4F;
      3'd2:    c = 8'h4B;
      3'd3:    c = 8'h23;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Packet head "!ADC="
  function automatic logic [7:0] head_text(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h21;
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h44;
      3'd3:    c = 8'h43;
      3'd4:    c = 8'h3D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[src/fcar_front.sv]
// Front end: frames received bytes, counts ticks and issues packet commands.
module fcar_front #(
  parameter int FRAME_DEPTH = 32,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic                     in_opcode,
  input  logic [7:0]               in_rx_byte,
  input  logic [SAMPLE_BITS-1:0]   in_adc_sample,
  input  logic                     cfg_wr_en,
  input  logic [fcar_pkg::TICK_W-1:0] cfg_wr_data,
  output logic                     cmd_push,
  output logic [SAMPLE_BITS:0]     cmd_data,
  input  logic                     cmd_full
);
  import fcar_pkg::*;

  localparam int LEN_W = $clog2(FRAME_DEPTH);

  logic [LEN_W-1:0]       len_r, len_nxt;
  logic                   rst_m_r, rst_m_nxt;
  logic                   ok_m_r, ok_m_nxt;
  logic                   waiting_r, waiting_nxt;
  logic [TICK_W-1:0]      elapsed_r, elapsed_nxt;
  logic [TICK_W-1:0]      timeout_r, timeout_nxt;
  logic [SAMPLE_BITS-1:0] held_r, held_nxt;
  logic [TICK_W-1:0]      tick_inc;
  logic                   accept;

  // Stall input only when the command queue cannot take a packet
  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;

  // Classify the item and update framing, ack wait and tick state
  always_comb begin
    len_nxt     = len_r;
    rst_m_nxt   = rst_m_r;
    ok_m_nxt    = ok_m_r;
    waiting_nxt = waiting_r;
    elapsed_nxt = elapsed_r;
    held_nxt    = held_r;
    cmd_push    = 1'b0;
    cmd_data    = {1'b0, held_r};
    tick_inc    = (elapsed_r == TICK_MAX) ? elapsed_r : elapsed_r + TICK_W'(1);
    timeout_nxt = cfg_wr_en ? cfg_wr_data : timeout_r;

    if (accept) begin
      if (in_opcode == OPC_TICK) begin
        // Advance the saturating count and resend on timeout
        elapsed_nxt = tick_inc;
        if (waiting_r && (tick_inc >= timeout_r)) begin
          elapsed_nxt = '0;
          cmd_push    = 1'b1;
          cmd_data    = {1'b1, held_r};
        end
      end else if (in_rx_byte == START_MARK) begin
        // Restart the frame holding just the start mark
        len_nxt   = LEN_W'(1);
        rst_m_nxt = 1'b1;
        ok_m_nxt  = 1'b1;
      end else if (len_r != '0) begin
        // Append, tracking whether the frame still spells a known command
        if (len_r < LEN_W'(FRAME_DEPTH - 1)) begin
          len_nxt   = len_r + LEN_W'(1);
          rst_m_nxt = rst_m_r && (len_r < LEN_W'(RST_LEN)) &&
                      (in_rx_byte == rst_text(len_r[2:0]));
          ok_m_nxt  = ok_m_r && (len_r < LEN_W'(OK_LEN)) &&
                      (in_rx_byte == ok_text(len_r[2:0]));
        end else begin
          // Drop an overflowing frame
          len_nxt   = '0;
          rst_m_nxt = 1'b0;
          ok_m_nxt  = 1'b0;
        end
        if (in_rx_byte == END_MARK) begin
          if ((len_nxt == LEN_W'(RST_LEN)) && rst_m_nxt) begin
            held_nxt    = in_adc_sample;
            waiting_nxt = 1'b1;
            elapsed_nxt = '0;
            cmd_push    = 1'b1;
            cmd_data    = {1'b0, in_adc_sample};
          end else if ((len_nxt == LEN_W'(OK_LEN)) && ok_m_nxt) begin
            waiting_nxt = 1'b0;
          end
          len_nxt = '0;
        end
      end
    end
  end

  // Hold front state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      rst_m_r   <= 1'b0;
      ok_m_r    <= 1'b0;
      waiting_r <= 1'b0;
      elapsed_r <= '0;
      held_r    <= '0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      len_r     <= len_nxt;
      rst_m_r   <= rst_m_nxt;
      ok_m_r    <= ok_m_nxt;
      waiting_r <= waiting_nxt;
      elapsed_r <= elapsed_nxt;
      held_r    <= held_nxt;
      timeout_r <= timeout_nxt;
    end
  end

endmodule

[src/fcar_cmd_fifo.sv]
// Short queue of packet commands between the front and back ends.
module fcar_cmd_fifo #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  // Write entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

[src/fcar_back.sv]
// Back end: converts the sample to decimal and streams packet bytes out.
module fcar_back #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [SAMPLE_BITS:0]   cmd_data,
  input  logic                   cmd_empty,
  output logic                   cmd_pop,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [7:0]             out_tx_byte,
  output logic                   out_is_resend,
  output logic                   out_last_of_packet
);
  import fcar_pkg::*;

  localparam int NDIG   = (SAMPLE_BITS <= 9) ? 3 : ((SAMPLE_BITS <= 13) ? 4 : 5);
  localparam int BCD_W  = NDIG * 4;
  localparam int STEP_B = 4;
  localparam int STEPS  = (SAMPLE_BITS + STEP_B - 1) / STEP_B;
  localparam int BIN_W  = STEPS * STEP_B;
  localparam int SCNT_W = $clog2(STEPS + 1);

  typedef enum logic [1:0] {PH_HEAD, PH_DIGS, PH_TAIL} phase_t;

  logic                busy_r;
  phase_t              phase_r;
  logic [2:0]          idx_r;
  logic                resend_r;
  logic [BCD_W-1:0]    bcd_r;
  logic [BIN_W-1:0]    bin_r;
  logic [SCNT_W-1:0]   steps_r;
  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  logic                out_resend_r;
  logic                out_last_r;

  logic [BCD_W-1:0]    bcd_step;
  logic [BIN_W-1:0]    bin_step;
  logic [2:0]          top_dig;
  logic [3:0]          cur_dig;
  logic                byte_ok;
  logic                adv;
  logic                finish;
  logic                load;
  logic [7:0]          byte_sel;

  // Shift-and-add-three over four sample bits per cycle
  always_comb begin
    bcd_step = bcd_r;
    bin_step = bin_r;
    for (int s = 0; s < STEP_B; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_step[d*4 +: 4] >= 4'd5) begin
          bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
        end
      end
      bcd_step = {bcd_step[BCD_W-2:0], bin_step[BIN_W-1]};
      bin_step = {bin_step[BIN_W-2:0], 1'b0};
    end
  end

  // Find the most significant nonzero digit
  always_comb begin
    top_dig = 3'd0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) begin
        top_dig = 3'(d);
      end
    end
  end

  assign cur_dig = bcd_r[idx_r*4 +: 4];

  // Select the byte at the current packet position
  always_comb begin
    case (phase_r)
      PH_HEAD: byte_sel = head_text(idx_r);
      PH_DIGS: byte_sel = CHAR_ZERO + {4'd0, cur_dig};
      PH_TAIL: begin
        case (idx_r)
          3'd0:    byte_sel = END_MARK;
          3'd1:    byte_sel = CHAR_CR;
          default: byte_sel = CHAR_LF;
        endcase
      end
      default: byte_sel = 8'h00;
    endcase
  end

  // Hold off leaving the head until the decimal digits are ready
  assign byte_ok = !((phase_r == PH_HEAD) && (idx_r == 3'(HEAD_LEN - 1)) &&
                     (steps_r != '0));
  assign adv     = busy_r && byte_ok && (!out_valid_r || out_pop);
  assign finish  = adv && (phase_r == PH_TAIL) && (idx_r == 3'd2);
  assign cmd_pop = !busy_r || finish;
  assign load    = cmd_pop && !cmd_empty;

  assign out_empty          = !out_valid_r;
  assign out_tx_byte        = out_byte_r;
  assign out_is_resend      = out_resend_r;
  assign out_last_of_packet = out_last_r;

  // Sequence the packet and hold the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_HEAD;
      idx_r       <= 3'd0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Output register
      if (adv) begin
        out_valid_r  <= 1'b1;
        out_byte_r   <= byte_sel;
        out_resend_r <= resend_r;
        out_last_r   <= finish;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end

      // Decimal conversion runs on its own schedule
      if (steps_r != '0) begin
        bcd_r   <= bcd_step;
        bin_r   <= bin_step;
        steps_r <= steps_r - SCNT_W'(1);
      end

      if (load) begin
        busy_r   <= 1'b1;
        phase_r  <= PH_HEAD;
        idx_r    <= 3'd0;
        resend_r <= cmd_data[SAMPLE_BITS];
        bcd_r    <= '0;
        bin_r    <= BIN_W'(cmd_data[SAMPLE_BITS-1:0]);
        steps_r  <= SCNT_W'(STEPS);
      end else if (finish) begin
        busy_r <= 1'b0;
      end else if (adv) begin
        unique case (phase_r)
          PH_HEAD: begin
            if (idx_r == 3'(HEAD_LEN - 1)) begin
              phase_r <= PH_DIGS;
              idx_r   <= top_dig;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
          PH_DIGS: begin
            if (idx_r == 3'd0) begin
              phase_r <= PH_TAIL;
            end else begin
              idx_r <= idx_r - 3'd1;
            end
          end
          PH_TAIL: idx_r <= idx_r + 3'd1;
          default: phase_r <= PH_HEAD;
        endcase
      end
    end
  end

endmodule

[src/framed_command_ack_retransmit_core.sv]
// A closing byte of "!RST#" or a timeout tick queues a packet command; the back end
// loads it and registers the first packet byte. Throughput: one item per cycle while
// the two-entry command queue has room. Each packet streams one byte per cycle while
// out_pop keeps up: 8 bytes plus the sample's decimal digits, converted during the head.
// Reset (rst_n low, synchronous): frame, ack wait, tick count, sample and queues clear;
// the ack timeout returns to 1000 ticks. No clearing pass; items are taken right after.
module framed_command_ack_retransmit_core #(
  parameter int FRAME_DEPTH = 32,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_opcode,
  input  logic [7:0]                  in_rx_byte,
  input  logic [SAMPLE_BITS-1:0]      in_adc_sample,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [7:0]                  out_tx_byte,
  output logic                        out_is_resend,
  output logic                        out_last_of_packet,
  input  logic                        cfg_wr_en,
  input  logic [fcar_pkg::TICK_W-1:0] cfg_wr_data
);
  import fcar_pkg::*;

  localparam int CMD_W = SAMPLE_BITS + 1;

  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CMD_W-1:0] cmd_wdata, cmd_rdata;

  // Accept and classify items
  fcar_front #(
    .FRAME_DEPTH (FRAME_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_opcode     (in_opcode),
    .in_rx_byte    (in_rx_byte),
    .in_adc_sample (in_adc_sample),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_wdata),
    .cmd_full      (cmd_full)
  );

  // Buffer packet commands
  fcar_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_wdata),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_rdata),
    .empty     (cmd_empty)
  );

  // Stream packets out
  fcar_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_data           (cmd_rdata),
    .cmd_empty          (cmd_empty),
    .cmd_pop            (cmd_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_tx_byte        (out_tx_byte),
    .out_is_resend      (out_is_resend),
    .out_last_of_packet (out_last_of_packet)
  );

endmodule
